/* rtl/core/fpfa_pkg.sv */
// fpfa_pkg: widths, codes and the table entry type of the fit allocator
// shared by fpfa_table, the allocator core and its checker; no dependencies
`default_nettype none

package fpfa_pkg;

    localparam int NUM_PARTITIONS_DEF = 8;
    localparam int SIZE_W             = 16;
    localparam int IDX_IN_W           = 3;
    localparam int STATUS_W           = 2;
    localparam int POLICY_W           = 2;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_LOADED  = 2'd0;
    localparam t_status ST_GRANTED = 2'd1;
    localparam t_status ST_NOFIT   = 2'd2;

    typedef logic [POLICY_W-1:0] t_policy;
    localparam t_policy POL_FIRST = 2'd0;
    localparam t_policy POL_BEST  = 2'd1;
    localparam t_policy POL_WORST = 2'd2;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              used;
    } t_entry;

    // an entry never loaded reads as size zero, in use
    localparam t_entry ENTRY_RESET = '{size: '0, used: 1'b1};

endpackage

`default_nettype wire

/* rtl/core/fpfa_table.sv */
// fpfa_table: partition table memory, one write and one read port, read data registered
// depends on fpfa_pkg for the entry type and its reset value
`default_nettype none

module fpfa_table
    import fpfa_pkg::*;
#(
    parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
    parameter int IDX_W          = $clog2(NUM_PARTITIONS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_entry           i_wr_entry,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_entry                o_rd_entry
);

    t_entry                    r_mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0] r_valid;
    t_entry                    r_rd_data;
    logic                      r_rd_vld;

    // valid bits stand in for the reset of the table contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_vld ? r_rd_data : ENTRY_RESET;

endmodule

`default_nettype wire

/* rtl/core/fixed_partition_fit_allocator_core.sv */
// fixed_partition_fit_allocator_core: fixed partition allocator, first, best or worst fit
// depends on fpfa_pkg and instantiates fpfa_table
//
// usage
//   command channel: an item is taken at a clock edge with start high and busy
//   low. operation load writes the size of one partition and frees it; a load
//   beyond the table writes nothing but still reports. operation request looks
//   for a free partition of at least the given size under the fit policy.
//   result channel: o_done is high for one cycle with status, index and size;
//   the receiver cannot stall, so every result must be taken in that cycle.
//   configuration: i_cfg_valid with i_cfg_data writes the fit policy; always
//   ready, to be written only while the block is idle.
// result timing and throughput
//   load: result in the cycle after the transfer, busy stays low, so loads go
//   back to back at one per cycle.
//   request: the table memory is read one entry per cycle, the scan visits
//   every partition in turn and writes the used mark back in its last step;
//   result and busy low come together after the scan, so busy holds off a
//   new command until the request is through.
// reset: all partitions read as size zero and in use, policy first fit.
`default_nettype none

module fixed_partition_fit_allocator_core
    import fpfa_pkg::*;
#(
    parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_operation,
    input  wire logic [IDX_IN_W-1:0] i_partition_index,
    input  wire logic [SIZE_W-1:0]   i_size,
    output logic                     o_done,
    output logic [STATUS_W-1:0]      o_status,
    output logic [IDX_IN_W-1:0]      o_granted_index,
    output logic [SIZE_W-1:0]        o_granted_size,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [POLICY_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(NUM_PARTITIONS);
    // wide enough for any table index, for NUM_PARTITIONS itself and for the input index
    localparam int AW    = (IDX_W + 1 > IDX_IN_W) ? IDX_W + 1 : IDX_IN_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_cnt, n_cnt;
    logic [SIZE_W-1:0]   r_want, n_want;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_pick_idx, n_pick_idx;
    logic [SIZE_W-1:0]   r_pick_size, n_pick_size;
    t_policy             r_fit_policy;
    logic                r_done, n_done;
    t_status             r_status, n_status;
    logic [IDX_IN_W-1:0] r_gidx, n_gidx;
    logic [SIZE_W-1:0]   r_gsize, n_gsize;

    logic                accept;
    logic [AW-1:0]       ld_ext;
    logic                ld_in_range;
    logic                last;
    t_entry              rd_entry;
    logic                fits;
    logic                improve;
    logic                take;
    logic [IDX_W-1:0]    sel_idx;
    logic [SIZE_W-1:0]   sel_size;
    logic                sel_found;
    logic [AW-1:0]       sel_idx_ext;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_entry;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;

    assign busy        = (r_state == S_SCAN);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign ld_ext      = AW'(i_partition_index);
    assign ld_in_range = ld_ext < AW'(NUM_PARTITIONS);
    assign last        = (r_cnt == IDX_W'(NUM_PARTITIONS - 1));

    // compare the entry that the memory returns with the best pick so far
    assign fits = !rd_entry.used && (rd_entry.size >= r_want);

    always_comb begin
        unique case (r_fit_policy)
            POL_BEST:  improve = rd_entry.size < r_pick_size;
            POL_WORST: improve = rd_entry.size > r_pick_size;
            default:   improve = 1'b0;
        endcase
    end

    assign take        = fits && (!r_found || improve);
    assign sel_idx     = take ? r_cnt : r_pick_idx;
    assign sel_size    = take ? rd_entry.size : r_pick_size;
    assign sel_found   = r_found || take;
    assign sel_idx_ext = AW'(sel_idx);

    // memory ports: loads write straight away, a request marks its pick in the last scan cycle
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = ld_ext[IDX_W-1:0];
        wr_entry = '{size: i_size, used: 1'b0};
        rd_en    = 1'b0;
        rd_addr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_LOAD) begin
                    wr_en = ld_in_range;
                end
                if (accept && i_operation == OP_REQUEST) begin
                    rd_en = 1'b1;
                end
            end
            S_SCAN: begin
                if (last) begin
                    wr_en    = sel_found;
                    wr_addr  = sel_idx;
                    wr_entry = '{size: sel_size, used: 1'b1};
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt + 1'b1;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_want      = r_want;
        n_found     = r_found;
        n_pick_idx  = r_pick_idx;
        n_pick_size = r_pick_size;
        n_done      = 1'b0;
        n_status    = r_status;
        n_gidx      = r_gidx;
        n_gsize     = r_gsize;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_LOAD) begin
                    n_done   = 1'b1;
                    n_status = ST_LOADED;
                    n_gidx   = '0;
                    n_gsize  = '0;
                end else if (accept) begin
                    n_state     = S_SCAN;
                    n_cnt       = '0;
                    n_want      = i_size;
                    n_found     = 1'b0;
                    n_pick_idx  = '0;
                    n_pick_size = '0;
                end
            end
            S_SCAN: begin
                n_found     = sel_found;
                n_pick_idx  = sel_idx;
                n_pick_size = sel_size;
                if (last) begin
                    n_state  = S_IDLE;
                    n_done   = 1'b1;
                    n_status = sel_found ? ST_GRANTED : ST_NOFIT;
                    n_gidx   = sel_found ? sel_idx_ext[IDX_IN_W-1:0] : '0;
                    n_gsize  = sel_found ? sel_size : '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_fit_policy <= POL_FIRST;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fit_policy <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_want      <= n_want;
        r_found     <= n_found;
        r_pick_idx  <= n_pick_idx;
        r_pick_size <= n_pick_size;
        r_status    <= n_status;
        r_gidx      <= n_gidx;
        r_gsize     <= n_gsize;
    end

    fpfa_table #(
        .NUM_PARTITIONS (NUM_PARTITIONS),
        .IDX_W          (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry)
    );

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_index = r_gidx;
    assign o_granted_size  = r_gsize;

endmodule

`default_nettype wire

/* rtl/core/fpfa_checker.sv */
// fpfa_checker: port level checks of the fit allocator, bound to its top level
// depends on fpfa_pkg for the operation and status codes
`default_nettype none

module fpfa_checker
    import fpfa_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                i_operation,
    input wire logic                o_done,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [IDX_IN_W-1:0] o_granted_index,
    input wire logic [SIZE_W-1:0]   o_granted_size
);

    // a load transfer reports loaded in the next cycle
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation == OP_LOAD |=> o_done && o_status == ST_LOADED)
        else $error("load transfer without loaded result");

    // a request transfer raises busy, without a result, as the scan starts
    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation == OP_REQUEST |=> busy && !o_done)
        else $error("request transfer did not start a scan");

    // the end of a scan always delivers a request outcome
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done && (o_status == ST_GRANTED || o_status == ST_NOFIT))
        else $error("scan ended without a request result");

    // only a grant carries an index and a size
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != ST_GRANTED |-> o_granted_index == '0 && o_granted_size == '0)
        else $error("non-grant result with index or size set");

endmodule

bind fixed_partition_fit_allocator_core fpfa_checker u_fpfa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_operation     (i_operation),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_granted_index (o_granted_index),
    .o_granted_size  (o_granted_size)
);

`default_nettype wire

/* tb/tb_fixed_partition_fit_allocator_core.sv */
// tb_fixed_partition_fit_allocator_core: self-checking bench for the partition fit allocator
// runs directed cases for each fit policy, then random load/request traffic checked
// against a local model of the partition table; depends on fpfa_pkg and the core
`timescale 1ns / 100ps

module tb_fixed_partition_fit_allocator_core;
    import fpfa_pkg::*;

    localparam int      NUM_PARTS   = NUM_PARTITIONS_DEF;
    localparam t_policy POL_UNUSED  = 2'd3;
    localparam int      PHASE_ITEMS = 250;

    typedef struct packed {
        t_status             status;
        logic [IDX_IN_W-1:0] index;
        logic [SIZE_W-1:0]   size;
    } t_outcome;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                start             = 1'b0;
    logic                i_operation       = OP_LOAD;
    logic [IDX_IN_W-1:0] i_partition_index = '0;
    logic [SIZE_W-1:0]   i_size            = '0;
    logic                i_cfg_valid       = 1'b0;
    logic [POLICY_W-1:0] i_cfg_data        = POL_FIRST;
    logic                busy;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [IDX_IN_W-1:0] o_granted_index;
    logic [SIZE_W-1:0]   o_granted_size;
    logic                o_cfg_ready;

    // local copy of the partition table and policy
    logic [SIZE_W-1:0] part_size [NUM_PARTS];
    logic              part_used [NUM_PARTS];
    t_policy           cur_policy;

    t_outcome pending_outcomes [$];
    t_outcome head_outcome;
    int       error_count = 0;
    bit       no_idle     = 1'b0;

    fixed_partition_fit_allocator_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_partition_index (i_partition_index),
        .i_size            (i_size),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_granted_index   (o_granted_index),
        .o_granted_size    (o_granted_size),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // applies one item to the local table and returns the outcome it should give
    function automatic t_outcome allocate_or_load(logic op, logic [IDX_IN_W-1:0] idx,
                                                  logic [SIZE_W-1:0] sz);
        t_outcome res;
        int       pick;
        res  = '0;
        pick = -1;
        if (op == OP_LOAD) begin
            if (idx < NUM_PARTS) begin
                part_size[idx] = sz;
                part_used[idx] = 1'b0;
            end
            res.status = ST_LOADED;
            return res;
        end
        for (int i = 0; i < NUM_PARTS; i++) begin
            if (!part_used[i] && part_size[i] >= sz) begin
                if (pick < 0) begin
                    pick = i;
                end else if (cur_policy == POL_BEST && part_size[i] < part_size[pick]) begin
                    pick = i;
                end else if (cur_policy == POL_WORST && part_size[i] > part_size[pick]) begin
                    pick = i;
                end
            end
        end
        if (pick < 0) begin
            res.status = ST_NOFIT;
        end else begin
            part_used[pick] = 1'b1;
            res.status = ST_GRANTED;
            res.index  = pick[IDX_IN_W-1:0];
            res.size   = part_size[pick];
        end
        return res;
    endfunction

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 10) return 0;
        if (r < 18) return $urandom_range(1, 12);
        return $urandom_range(20, 60);
    endfunction

    // extremes and a few repeated sizes so that ties turn up
    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return SIZE_W'($urandom_range(1, 4) * 64);
            default: return SIZE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [IDX_IN_W-1:0] idx,
                             input logic [SIZE_W-1:0] sz);
        int gap;
        gap = rand_gap();
        start             <= 1'b1;
        i_operation       <= op;
        i_partition_index <= idx;
        i_size            <= sz;
        do @(posedge i_clk); while (busy);
        pending_outcomes.push_back(allocate_or_load(op, idx, sz));
        // start stays high when the next transfer follows straight on
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request(input logic [SIZE_W-1:0] sz);
        send_item(OP_REQUEST, IDX_IN_W'($urandom_range(0, NUM_PARTS - 1)), sz);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_policy(input t_policy pol);
        drain();
        repeat (NUM_PARTS + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pol;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_policy = pol;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        // nothing is free after reset, not even for a zero-size request
        send_request('0);
        send_request('1);
    endtask

    task automatic test_first_fit();
        send_item(OP_LOAD, 3'd0, 16'd300);
        send_item(OP_LOAD, 3'd1, 16'd100);
        send_item(OP_LOAD, 3'd2, 16'd500);
        send_item(OP_LOAD, 3'd3, 16'd100);
        send_item(OP_LOAD, 3'd4, 16'd0);
        send_item(OP_LOAD, 3'd5, 16'hFFFF);
        send_item(OP_LOAD, 3'd6, 16'd100);
        send_item(OP_LOAD, 3'd7, 16'd0);
        send_request(16'd100);
        send_request(16'hFFFF);
        send_request(16'hFFFF);
    endtask

    task automatic test_best_fit();
        write_policy(POL_BEST);
        send_request(16'd50);
        send_request(16'd0);
    endtask

    task automatic test_worst_fit_reload();
        write_policy(POL_WORST);
        send_request(16'd1);
        send_request(16'd1);
        // partition 2 is in use here; a load frees it again
        send_item(OP_LOAD, 3'd2, 16'd200);
        send_request(16'd150);
    endtask

    task automatic test_unused_policy();
        write_policy(POL_UNUSED);
        send_request(16'd0);
        send_request(16'd0);
        send_request(16'd0);
    endtask

    task automatic test_random_traffic();
        t_policy phase_pol [5];
        int      sent;
        int      n_load;
        int      n_req;
        phase_pol = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_FIRST};
        phase_pol[4] = POLICY_W'($urandom_range(0, 3));
        for (int p = 0; p < 5; p++) begin
            write_policy(phase_pol[p]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                no_idle = ($urandom_range(0, 9) < 3);
                if ($urandom_range(0, 99) < 85) begin
                    // refill part of the table, then allocate from it
                    n_load = $urandom_range(1, NUM_PARTS);
                    n_req  = $urandom_range(1, NUM_PARTS + 2);
                    repeat (n_load) send_item(OP_LOAD,
                                              IDX_IN_W'($urandom_range(0, NUM_PARTS - 1)),
                                              rand_size());
                    repeat (n_req) send_request(rand_size() >> $urandom_range(0, 3));
                    sent += n_load + n_req;
                end else begin
                    n_load = $urandom_range(1, 6);
                    repeat (n_load) send_item(1'($urandom_range(0, 1)),
                                              IDX_IN_W'($urandom_range(0, 7)),
                                              SIZE_W'($urandom_range(0, 65535)));
                    sent += n_load;
                end
            end
            no_idle = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no transfer outstanding: status %0d index %0d size %0d",
                       o_status, o_granted_index, o_granted_size);
                error_count++;
            end else begin
                head_outcome = pending_outcomes.pop_front();
                if (o_status !== head_outcome.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           head_outcome.status, o_status);
                    error_count++;
                end
                if (o_granted_index !== head_outcome.index) begin
                    $error("granted_index mismatch: expected %0d, actual %0d",
                           head_outcome.index, o_granted_index);
                    error_count++;
                end
                if (o_granted_size !== head_outcome.size) begin
                    $error("granted_size mismatch: expected %0d, actual %0d",
                           head_outcome.size, o_granted_size);
                    error_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_PARTS; i++) begin
            part_size[i] = '0;
            part_used[i] = 1'b1;
        end
        cur_policy = POL_FIRST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_first_fit();
        test_best_fit();
        test_worst_fit_reload();
        test_unused_policy();
        test_random_traffic();

        drain();
        repeat (NUM_PARTS + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
